>>> hw/rtl/tknf_pkg.sv
// ============================================================================
// tknf_pkg - shared types and constants for the top-k nearest match block
// Field widths, action codes, queue depths and the word layouts that pass
// between the front end, the back end and the ports.
// ============================================================================
`default_nettype none

package tknf_pkg;

    localparam int VALUE_W     = 24;
    localparam int ENTRY_W     = 10;
    localparam int COMP_W      = 6;
    localparam int RANK_W      = 4;
    localparam int DIST_W      = 57;
    localparam int MAG_W       = 24;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int TOP_COUNT_W = 5;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam int MAX_KEEP_DEF     = 16;
    localparam int MAX_FEATURES_DEF = 64;
    localparam int CMD_DEPTH        = 4;
    localparam int RES_DEPTH        = 2;

    localparam logic [DIST_W-1:0]      DIST_MAX        = '1;
    localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = 5'd1;

    // action codes
    localparam logic [1:0] ACT_LOAD    = 2'd0;
    localparam logic [1:0] ACT_LIBRARY = 2'd1;
    localparam logic [1:0] ACT_REPORT  = 2'd2;
    localparam logic [1:0] ACT_NONE    = 2'd3;

    // register index (paddr[2])
    localparam logic REG_TOP_COUNT = 1'b0;

    typedef struct packed {
        logic [1:0]                action;
        logic [ENTRY_W-1:0]        entry_index;
        logic [COMP_W-1:0]         component_index;
        logic signed [VALUE_W-1:0] component_value;
        logic                      last_component;
    } t_item;

    typedef struct packed {
        logic [RANK_W-1:0]  rank;
        logic [ENTRY_W-1:0] match_index;
        logic [DIST_W-1:0]  squared_distance;
        logic               found;
        logic               last_result;
    } t_result;

    // classified word handed from front to back
    typedef struct packed {
        logic [1:0]                op;
        logic                      in_range;
        logic [ENTRY_W-1:0]        entry_index;
        logic [COMP_W-1:0]         component_index;
        logic signed [VALUE_W-1:0] value;
        logic                      last;
    } t_cmd;

endpackage

`default_nettype wire

>>> hw/rtl/top_k_nearest_feature_match.sv
// ============================================================================
// top_k_nearest_feature_match - top-k nearest library match by squared L2
// Query store, streaming distance accumulation and a sorted best-k list,
// with a queue-style word interface and an APB register for the list size.
// ============================================================================
// Load query components first (action 0), then stream each library vector
// one component per word (action 1), marking its final word with
// last_component; that word's entry joins an ascending list of the
// top_count nearest entries, ties ranking after earlier ones. Action 2
// reports the list nearest first, one result word per match and last_result
// on the final one, then empties it; an empty list reports a single word
// with found = 0. Action 3 is taken and discarded. A four-word command queue
// decouples the input port from the execution sequencer, which handles a
// query load in its idle state; a library component passes through query
// store read, difference, 24x24 square and saturating accumulate, and the
// word closing a vector enters an insert step, where all list cells compare
// and shift in parallel. A report emits one result word per cycle, held back
// only while the two-word result queue is full. No clearing pass follows
// reset: query entries are simply undefined until loaded. top_count (register
// 0, byte address 0, reset 1) must be written only while the block is idle,
// unenforced by the block; 0 acts as 1 and values above MAX_KEEP as MAX_KEEP.
// ============================================================================
`default_nettype none

module top_k_nearest_feature_match #(
    parameter int MAX_KEEP     = tknf_pkg::MAX_KEEP_DEF,
    parameter int MAX_FEATURES = tknf_pkg::MAX_FEATURES_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    // input word queue
    input  wire logic                               push,
    output logic                                    full,
    input  wire tknf_pkg::t_item                    i_item,
    // result word queue
    output logic                                    empty,
    input  wire logic                               pop,
    output tknf_pkg::t_result                       o_result,
    // register port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [tknf_pkg::APB_ADDR_W-1:0]    paddr,
    input  wire logic [tknf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic      [tknf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                                    pready
);

    import tknf_pkg::*;

    logic [TOP_COUNT_W-1:0]     r_top_count;
    logic                       cfg_wr;
    t_cmd                       cmd;
    logic                       cmd_valid;
    logic                       cmd_pop;
    logic                       res_push;
    t_result                    res;
    logic                       res_full;
    logic [$bits(t_result)-1:0] res_word;

    // ---- registers ---------------------------------------------------------
    // no wait states; register index lives in paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TOP_COUNT);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_count <= TOP_COUNT_RESET;
        end else if (cfg_wr) begin
            r_top_count <= pwdata[TOP_COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[2] == REG_TOP_COUNT) begin
            prdata = APB_DATA_W'(r_top_count);
        end else begin
            prdata = '0;
        end
    end

    // ---- front: accept and classify ---------------------------------------
    tknf_front #(
        .MAX_FEATURES (MAX_FEATURES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_cmd       (cmd),
        .o_cmd_valid (cmd_valid),
        .i_cmd_pop   (cmd_pop)
    );

    // ---- back: distance, ranking, report ----------------------------------
    tknf_back #(
        .MAX_KEEP     (MAX_KEEP),
        .MAX_FEATURES (MAX_FEATURES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_top_count (r_top_count),
        .i_cmd       (cmd),
        .i_cmd_valid (cmd_valid),
        .o_cmd_pop   (cmd_pop),
        .o_res_push  (res_push),
        .o_res       (res),
        .i_res_full  (res_full)
    );

    // ---- result queue ------------------------------------------------------
    // lets the sequencer run on while the oldest result word waits
    tknf_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (RES_DEPTH)
    ) u_res_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (res_push),
        .i_wr_data (res),
        .o_full    (res_full),
        .i_rd_en   (pop),
        .o_rd_data (res_word),
        .o_empty   (empty)
    );

    assign o_result = t_result'(res_word);

endmodule

`default_nettype wire

>>> hw/rtl/tknf_fifo.sv
// ============================================================================
// tknf_fifo - small register queue
// Fall-through read of the oldest word; full and empty flags from a count.
// ============================================================================
`default_nettype none

module tknf_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr_en,
    input  wire logic [WIDTH-1:0] i_wr_data,
    output logic                  o_full,
    input  wire logic             i_rd_en,
    output logic      [WIDTH-1:0] o_rd_data,
    output logic                  o_empty
);

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0]  r_count,  n_count;
    logic             wr_go, rd_go;

    assign o_full    = (r_count == CNTW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_rd_data = r_mem[r_rd_ptr];
    assign wr_go     = i_wr_en && !o_full;
    assign rd_go     = i_rd_en && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_go) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (rd_go) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (wr_go && !rd_go) begin
            n_count = r_count + 1'b1;
        end else if (rd_go && !wr_go) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_go) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/tknf_front.sv
// ============================================================================
// tknf_front - input side
// Takes words from the input queue port, drops unused actions, range-checks
// the component index and queues the classified word for the back end.
// ============================================================================
`default_nettype none

module tknf_front #(
    parameter int MAX_FEATURES = tknf_pkg::MAX_FEATURES_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    output logic                o_full,
    input  wire tknf_pkg::t_item i_item,
    output tknf_pkg::t_cmd      o_cmd,
    output logic                o_cmd_valid,
    input  wire logic           i_cmd_pop
);

    import tknf_pkg::*;

    t_cmd                cmd_in;
    logic [$bits(t_cmd)-1:0] cmd_out;
    logic                wr_en;
    logic                q_empty;

    always_comb begin
        cmd_in.op              = i_item.action;
        cmd_in.in_range        = (32'(i_item.component_index) < 32'(MAX_FEATURES));
        cmd_in.entry_index     = i_item.entry_index;
        cmd_in.component_index = i_item.component_index;
        cmd_in.value           = i_item.component_value;
        cmd_in.last            = i_item.last_component;
    end

    // unused action code is accepted and dropped here
    assign wr_en = i_push && !o_full && (i_item.action != ACT_NONE);

    tknf_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_q (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (wr_en),
        .i_wr_data (cmd_in),
        .o_full    (o_full),
        .i_rd_en   (i_cmd_pop),
        .o_rd_data (cmd_out),
        .o_empty   (q_empty)
    );

    assign o_cmd       = t_cmd'(cmd_out);
    assign o_cmd_valid = !q_empty;

endmodule

`default_nettype wire

>>> hw/rtl/tknf_back.sv
// ============================================================================
// tknf_back - execution side
// Query store, square-accumulate datapath, compare-shift ranking cells and
// the report sequencer that feeds the result queue.
// ============================================================================
`default_nettype none

module tknf_back #(
    parameter int MAX_KEEP     = tknf_pkg::MAX_KEEP_DEF,
    parameter int MAX_FEATURES = tknf_pkg::MAX_FEATURES_DEF
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic [tknf_pkg::TOP_COUNT_W-1:0]    i_top_count,
    input  wire tknf_pkg::t_cmd                      i_cmd,
    input  wire logic                                i_cmd_valid,
    output logic                                     o_cmd_pop,
    output logic                                     o_res_push,
    output tknf_pkg::t_result                        o_res,
    input  wire logic                                i_res_full
);

    import tknf_pkg::*;

    localparam int QW  = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int CXW = (QW > COMP_W) ? QW : COMP_W;
    localparam int FW  = $clog2(MAX_KEEP + 1);
    localparam int KCW = (FW > TOP_COUNT_W) ? FW : TOP_COUNT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DIFF = 3'd1;
    localparam logic [2:0] S_MUL  = 3'd2;
    localparam logic [2:0] S_ACC  = 3'd3;
    localparam logic [2:0] S_INS  = 3'd4;
    localparam logic [2:0] S_REP  = 3'd5;

    logic [2:0]                r_state, n_state;
    logic [DIST_W-1:0]         r_acc, n_acc;
    logic [FW-1:0]             r_fill, n_fill;
    logic [FW-1:0]             r_left, n_left;
    logic [RANK_W-1:0]         r_rank, n_rank;

    logic signed [VALUE_W-1:0] query_mem [MAX_FEATURES];
    logic signed [VALUE_W-1:0] r_q;
    logic signed [VALUE_W-1:0] r_value;
    logic                      r_in_range;
    logic                      r_last;
    logic [ENTRY_W-1:0]        r_entry;
    logic [MAG_W-1:0]          r_mag;
    logic [SQ_W-1:0]           r_sq;
    logic [DIST_W-1:0]         r_ins_dist;
    logic [ENTRY_W-1:0]        r_ins_idx;

    logic [DIST_W-1:0]         r_dist [MAX_KEEP];
    logic [ENTRY_W-1:0]        r_idx  [MAX_KEEP];
    logic [DIST_W-1:0]         prev_dist [MAX_KEEP];
    logic [ENTRY_W-1:0]        prev_idx  [MAX_KEEP];
    logic [DIST_W-1:0]         next_dist [MAX_KEEP];
    logic [ENTRY_W-1:0]        next_idx  [MAX_KEEP];
    logic [MAX_KEEP-1:0]       le, hit, take_new;

    logic [CXW-1:0]            cidx_ext;
    logic [QW-1:0]             q_addr;
    logic                      mem_we;
    logic [KCW-1:0]            tc_ext, k_wide;
    logic [FW-1:0]             k, fill_c;
    logic [VALUE_W:0]          q_ext, d_w, d_neg, mag_w;
    logic [DIST_W:0]           acc_sum;
    logic [DIST_W-1:0]         acc_new;
    logic                      ins_ok;
    logic                      ins_go;
    logic                      rep_empty;
    logic                      shift_go;

    // ---- query store: one write port, registered read --------------------
    assign cidx_ext = CXW'(i_cmd.component_index);
    assign q_addr   = cidx_ext[QW-1:0];
    assign mem_we   = o_cmd_pop && (i_cmd.op == ACT_LOAD) && i_cmd.in_range;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            query_mem[q_addr] <= i_cmd.value;
        end
        r_q <= query_mem[q_addr];
    end

    // ---- keep limit ------------------------------------------------------
    always_comb begin
        tc_ext = KCW'(i_top_count);
        if (tc_ext == '0) begin
            k_wide = KCW'(1);
        end else if (tc_ext > KCW'(MAX_KEEP)) begin
            k_wide = KCW'(MAX_KEEP);
        end else begin
            k_wide = tc_ext;
        end
        k      = k_wide[FW-1:0];
        fill_c = (r_fill > k) ? k : r_fill;
    end

    // ---- distance datapath -----------------------------------------------
    always_comb begin
        q_ext   = r_in_range ? {r_q[VALUE_W-1], r_q} : '0;
        d_w     = {r_value[VALUE_W-1], r_value} - q_ext;
        d_neg   = ~d_w + 1'b1;
        mag_w   = d_w[VALUE_W] ? d_neg : d_w;
        acc_sum = {1'b0, r_acc} + (DIST_W + 1)'(r_sq);
        acc_new = acc_sum[DIST_W] ? DIST_MAX : acc_sum[DIST_W-1:0];
    end

    // ---- compare-shift cells ---------------------------------------------
    genvar g;
    generate
        for (g = 0; g < MAX_KEEP; g++) begin : g_cell
            assign le[g]  = (FW'(g) < fill_c) && (r_dist[g] <= r_ins_dist);
            assign hit[g] = le[g] && ((FW'(g) + 1'b1) == k);
            if (g == 0) begin : g_head
                assign take_new[g]  = !le[g];
                assign prev_dist[g] = r_ins_dist;
                assign prev_idx[g]  = r_ins_idx;
            end else begin : g_body
                assign take_new[g]  = !le[g] && le[g-1];
                assign prev_dist[g] = r_dist[g-1];
                assign prev_idx[g]  = r_idx[g-1];
            end
            if (g == MAX_KEEP - 1) begin : g_tail
                assign next_dist[g] = r_dist[g];
                assign next_idx[g]  = r_idx[g];
            end else begin : g_mid
                assign next_dist[g] = r_dist[g+1];
                assign next_idx[g]  = r_idx[g+1];
            end

            always_ff @(posedge i_clk) begin
                if (ins_go && !le[g]) begin
                    r_dist[g] <= take_new[g] ? r_ins_dist : prev_dist[g];
                    r_idx[g]  <= take_new[g] ? r_ins_idx  : prev_idx[g];
                end else if (shift_go) begin
                    r_dist[g] <= next_dist[g];
                    r_idx[g]  <= next_idx[g];
                end
            end
        end
    endgenerate

    // full list and new distance not strictly below the tail: no entry
    assign ins_ok = ~|hit;
    assign ins_go = (r_state == S_INS) && ins_ok;

    // ---- report words ----------------------------------------------------
    assign rep_empty  = (r_left == '0);
    assign o_res_push = (r_state == S_REP) && !i_res_full;
    assign shift_go   = o_res_push && !rep_empty;

    always_comb begin
        o_res.rank             = r_rank;
        o_res.match_index      = rep_empty ? '0 : r_idx[0];
        o_res.squared_distance = rep_empty ? '0 : r_dist[0];
        o_res.found            = !rep_empty;
        o_res.last_result      = rep_empty || (r_left == FW'(1));
    end

    // ---- sequencer ---------------------------------------------------------
    assign o_cmd_pop = (r_state == S_IDLE) && i_cmd_valid;

    always_comb begin
        n_state = r_state;
        n_acc   = r_acc;
        n_fill  = r_fill;
        n_left  = r_left;
        n_rank  = r_rank;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_pop) begin
                    case (i_cmd.op)
                        ACT_LIBRARY: begin
                            n_state = S_DIFF;
                        end
                        ACT_REPORT: begin
                            n_state = S_REP;
                            n_left  = fill_c;
                            n_rank  = '0;
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_DIFF: begin
                n_state = S_MUL;
            end
            S_MUL: begin
                n_state = S_ACC;
            end
            S_ACC: begin
                if (r_last) begin
                    n_acc   = '0;
                    n_state = S_INS;
                end else begin
                    n_acc   = acc_new;
                    n_state = S_IDLE;
                end
            end
            S_INS: begin
                if (ins_ok && (fill_c < k)) begin
                    n_fill = fill_c + 1'b1;
                end else begin
                    n_fill = fill_c;
                end
                n_state = S_IDLE;
            end
            S_REP: begin
                if (o_res_push) begin
                    if (o_res.last_result) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_left = r_left - 1'b1;
                        n_rank = r_rank + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_fill  <= '0;
            r_left  <= '0;
            r_rank  <= '0;
        end else begin
            r_state <= n_state;
            r_acc   <= n_acc;
            r_fill  <= n_fill;
            r_left  <= n_left;
            r_rank  <= n_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_value    <= i_cmd.value;
            r_in_range <= i_cmd.in_range;
            r_last     <= i_cmd.last;
            r_entry    <= i_cmd.entry_index;
        end
        r_mag <= mag_w[MAG_W-1:0];
        r_sq  <= r_mag * r_mag;
        if ((r_state == S_ACC) && r_last) begin
            r_ins_dist <= acc_new;
            r_ins_idx  <= r_entry;
        end
    end

    // ---- checks ------------------------------------------------------------
    a_ins_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |-> ($past(r_state) == S_ACC && r_acc == '0))
        else $error("insertion not preceded by a closing accumulate");

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(MAX_KEEP))
        else $error("fill count beyond list depth");

    a_report_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_push && o_res.last_result) |=> (r_fill == '0 && r_state == S_IDLE))
        else $error("list not emptied after report");

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_push |-> !o_cmd_pop)
        else $error("command taken during report");

endmodule

`default_nettype wire
